// ===== sv/alpq_pkg.sv =====
// ----------------------------------------------------------------------------
// AC line period qualifier package
// Shared types and constants: register indexes, reset values and the
// configuration and state records.
// ----------------------------------------------------------------------------
`default_nettype none

package alpq_pkg;

  localparam int unsigned PeriodW  = 16;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  // Reset values of the configuration registers.
  localparam logic [PeriodW-1:0] UpperLimitRst  = 16'd22222;
  localparam logic [PeriodW-1:0] LowerLimitRst  = 16'd15384;
  localparam logic [PeriodW-1:0] ToleranceRst   = 16'd30;
  localparam logic [CountW-1:0]  RunStartRst    = 8'd12;
  localparam logic [CountW-1:0]  RiseAcceptRst  = 8'd17;
  localparam logic [CountW-1:0]  FallAcceptRst  = 8'd70;
  localparam logic [CountW-1:0]  StartupRst     = 8'd70;
  localparam logic [CountW-1:0]  MissingRst     = 8'd5;

  // Accepted period after reset.
  localparam logic [PeriodW-1:0] HeldPeriodRst  = 16'd20000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_UPPER_LIMIT = 4'd0,
    REG_LOWER_LIMIT = 4'd1,
    REG_TOLERANCE   = 4'd2,
    REG_RUN_START   = 4'd3,
    REG_RISE_ACCEPT = 4'd4,
    REG_FALL_ACCEPT = 4'd5,
    REG_STARTUP     = 4'd6,
    REG_MISSING     = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [PeriodW-1:0] upper_limit;
    logic [PeriodW-1:0] lower_limit;
    logic [PeriodW-1:0] tolerance;
    logic [CountW-1:0]  run_start;
    logic [CountW-1:0]  rise_accept;
    logic [CountW-1:0]  fall_accept;
    logic [CountW-1:0]  startup_samples;
    logic [CountW-1:0]  missing_limit;
  } cfg_t;

  typedef struct packed {
    logic [PeriodW-1:0] held_period;
    logic [CountW-1:0]  outlier_run;
    logic [CountW-1:0]  startup_count;
    logic [CountW-1:0]  missing_count;
    logic               range_flag;
    logic               lost_flag;
  } state_t;

endpackage

`default_nettype wire

// ===== sv/alpq_if.sv =====
// ----------------------------------------------------------------------------
// AC line period qualifier channels
// Valid/ready interfaces for check items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface alpq_chk_if;
  logic        valid;
  logic        ready;
  logic [15:0] period_sample;
  logic        edge_seen;

  modport source (output valid, period_sample, edge_seen, input ready);
  modport sink   (input valid, period_sample, edge_seen, output ready);
endinterface

interface alpq_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] accepted_period;
  logic        range_alarm;
  logic        signal_lost_alarm;

  modport source (output valid, accepted_period, range_alarm, signal_lost_alarm,
                  input ready);
  modport sink   (input valid, accepted_period, range_alarm, signal_lost_alarm,
                  output ready);
endinterface

interface alpq_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ===== sv/alpq_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// AC line period qualifier register file
// Holds the eight configuration registers; writes to unknown indexes are
// dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module alpq_cfg_regs (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              wr_en_i,
  input  wire  [alpq_pkg::CfgIdxW-1:0]     wr_idx_i,
  input  wire  [alpq_pkg::CfgDataW-1:0]    wr_data_i,
  output alpq_pkg::cfg_t                   cfg_o
);
  import alpq_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_reg_e'(wr_idx_i))
        REG_UPPER_LIMIT: cfg_d.upper_limit     = wr_data_i;
        REG_LOWER_LIMIT: cfg_d.lower_limit     = wr_data_i;
        REG_TOLERANCE:   cfg_d.tolerance       = wr_data_i;
        REG_RUN_START:   cfg_d.run_start       = wr_data_i[CountW-1:0];
        REG_RISE_ACCEPT: cfg_d.rise_accept     = wr_data_i[CountW-1:0];
        REG_FALL_ACCEPT: cfg_d.fall_accept     = wr_data_i[CountW-1:0];
        REG_STARTUP:     cfg_d.startup_samples = wr_data_i[CountW-1:0];
        REG_MISSING:     cfg_d.missing_limit   = wr_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upper_limit     <= UpperLimitRst;
      cfg_q.lower_limit     <= LowerLimitRst;
      cfg_q.tolerance       <= ToleranceRst;
      cfg_q.run_start       <= RunStartRst;
      cfg_q.rise_accept     <= RiseAcceptRst;
      cfg_q.fall_accept     <= FallAcceptRst;
      cfg_q.startup_samples <= StartupRst;
      cfg_q.missing_limit   <= MissingRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/alpq_step.sv =====
// ----------------------------------------------------------------------------
// AC line period qualifier update logic
// Works out the next qualifier state from the present state and one check.
// ----------------------------------------------------------------------------
`default_nettype none

module alpq_step (
  input  wire  alpq_pkg::cfg_t             cfg_i,
  input  wire  alpq_pkg::state_t           st_i,
  input  wire  [alpq_pkg::PeriodW-1:0]     sample_i,
  input  wire                              edge_i,
  output alpq_pkg::state_t                 st_o
);
  import alpq_pkg::*;

  logic               rising;
  logic [PeriodW:0]   diff_abs;
  logic               changed;
  logic [CountW-1:0]  run_up;
  logic [CountW-1:0]  run_dn;
  logic [CountW-1:0]  start_inc;
  logic [CountW-1:0]  miss_base;
  logic [CountW-1:0]  miss_inc;
  logic [PeriodW-1:0] held_new;

  always_comb begin
    rising   = sample_i > st_i.held_period;
    diff_abs = rising ? ({1'b0, sample_i} - {1'b0, st_i.held_period})
                      : ({1'b0, st_i.held_period} - {1'b0, sample_i});
    changed  = diff_abs > {1'b0, cfg_i.tolerance};

    // Run counter moves away from its neutral value in the sign of the change.
    run_up = (st_i.outlier_run < cfg_i.run_start) ? cfg_i.run_start
                                                   : st_i.outlier_run + 8'd1;
    run_dn = (st_i.outlier_run > cfg_i.run_start) ? cfg_i.run_start
                                                   : st_i.outlier_run - 8'd1;

    start_inc = (st_i.startup_count == '1) ? st_i.startup_count
                                           : st_i.startup_count + 8'd1;
    miss_base = edge_i ? '0 : st_i.missing_count;
    miss_inc  = (miss_base == '1) ? miss_base : miss_base + 8'd1;

    st_o          = st_i;
    held_new      = st_i.held_period;
    st_o.missing_count = miss_inc;

    if (sample_i != '0) begin
      st_o.startup_count = start_inc;
      if (!changed) begin
        st_o.outlier_run = cfg_i.run_start;
      end else if (rising) begin
        if (run_up > cfg_i.rise_accept) begin
          st_o.outlier_run = cfg_i.run_start;
          held_new         = sample_i;
        end else begin
          st_o.outlier_run = run_up;
        end
      end else begin
        if (run_dn < cfg_i.fall_accept) begin
          st_o.outlier_run = cfg_i.run_start;
          held_new         = sample_i;
        end else begin
          st_o.outlier_run = run_dn;
        end
      end
    end
    st_o.held_period = held_new;

    if (st_o.startup_count >= cfg_i.startup_samples) begin
      st_o.startup_count = cfg_i.startup_samples;
      st_o.range_flag    = (held_new > cfg_i.upper_limit) ||
                           (held_new < cfg_i.lower_limit);
    end

    if (miss_inc >= cfg_i.missing_limit) begin
      st_o.missing_count = cfg_i.missing_limit;
      st_o.lost_flag     = 1'b1;
    end else begin
      st_o.lost_flag     = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ac_line_period_qualifier_unit.sv =====
// ----------------------------------------------------------------------------
// AC line period qualifier
// Qualifies measured mains periods against a held period, with asymmetric
// outlier runs, a range alarm after start-up and a signal-lost alarm.
// ----------------------------------------------------------------------------
//
//   Port    Direction  Item carried
//   ------  ---------  ----------------------------------------------------
//   chk_i   in         one check: period_sample (16 bit), edge_seen (1 bit)
//   res_o   out        one result: accepted_period, range_alarm,
//                      signal_lost_alarm
//   cfg_i   in         register write: index (4 bit), wdata (16 bit)
//
// Each check gives exactly one result. It waits in the input register, then
// passes through the update logic into the result register once that is
// empty or being emptied. The state update is a single short pass, so a check
// can be taken every cycle while results are taken. A stalled result holds in
// the result register while one further check waits in the input register;
// only then does chk_i drop ready. Reset puts the valid flags, configuration
// and qualifier state to documented values; the register port is always ready.
//
`default_nettype none

module ac_line_period_qualifier_unit (
  input  wire           clk_i,
  input  wire           rst_ni,
  alpq_chk_if.sink      chk_i,
  alpq_res_if.source    res_o,
  alpq_cfg_if.sink      cfg_i
);
  import alpq_pkg::*;

  cfg_t cfg;

  // Input register: one check waiting for the update logic.
  logic               in_valid_q, in_valid_d;
  logic [PeriodW-1:0] in_sample_q;
  logic               in_edge_q;

  // Result register and the qualifier state it reflects.
  logic   out_valid_q, out_valid_d;
  state_t st_q, st_d;

  logic advance;
  logic in_take;

  alpq_cfg_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.wdata),
    .cfg_o     (cfg)
  );

  alpq_step u_step (
    .cfg_i    (cfg),
    .st_i     (st_q),
    .sample_i (in_sample_q),
    .edge_i   (in_edge_q),
    .st_o     (st_d)
  );

  assign cfg_i.ready = 1'b1;

  // The held check moves on whenever the result register is empty or is being
  // emptied in this cycle.
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign chk_i.ready = !in_valid_q || advance;
  assign in_take     = chk_i.valid && chk_i.ready;

  always_comb begin
    in_valid_d  = in_take || (in_valid_q && !advance);
    out_valid_d = advance || (out_valid_q && !res_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q.held_period   <= HeldPeriodRst;
      st_q.outlier_run   <= RunStartRst;
      st_q.startup_count <= '0;
      st_q.missing_count <= '0;
      st_q.range_flag    <= 1'b0;
      st_q.lost_flag     <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_sample_q <= chk_i.period_sample;
      in_edge_q   <= chk_i.edge_seen;
    end
  end

  // The result register is the state itself: it changes only when a check
  // passes through, so a stalled result stays put.
  assign res_o.valid             = out_valid_q;
  assign res_o.accepted_period   = st_q.held_period;
  assign res_o.range_alarm       = st_q.range_flag;
  assign res_o.signal_lost_alarm = st_q.lost_flag;

endmodule

`default_nettype wire

// ===== sv/alpq_checker.sv =====
// ----------------------------------------------------------------------------
// AC line period qualifier checker
// Port-level assertions on result timing and back-pressure, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module alpq_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        chk_valid,
  input wire        chk_ready,
  input wire        res_valid,
  input wire        res_ready,
  input wire [15:0] res_period,
  input wire        res_range,
  input wire        res_lost
);

  // A stalled result keeps its valid and its payload.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=>
      res_valid && $stable(res_period) && $stable(res_range) && $stable(res_lost))
    else $error("stalled result changed");

  // A result on an empty output follows a check taken into the input register.
  a_res_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid) |-> $past(chk_valid && chk_ready, 2))
    else $error("result without a matching check");

  // With the result stalled and a check just taken, the input side only takes
  // another check when the result is taken in the same cycle.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready && chk_valid && chk_ready |=> chk_ready == res_ready)
    else $error("input ready not tied to result ready");

endmodule

bind ac_line_period_qualifier_unit alpq_checker u_alpq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .chk_valid  (chk_i.valid),
  .chk_ready  (chk_i.ready),
  .res_valid  (res_o.valid),
  .res_ready  (res_o.ready),
  .res_period (res_o.accepted_period),
  .res_range  (res_o.range_alarm),
  .res_lost   (res_o.signal_lost_alarm)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AC line period qualifier testbench
// Feeds periodic line checks into the qualifier and compares every result
// with an in-bench prediction of the held period and both alarms. The run
// covers the reset settings, both extremes of every register and several
// random settings, with random idling on both channels.
// ----------------------------------------------------------------------------

module testbench;
  import alpq_pkg::*;

  // The watchdog is far above the slowest legal run: roughly 1700 checks,
  // each at worst held up by the longest source gap, the longest result
  // stall and the pipeline.
  localparam int unsigned CycleLimit = 400000;

  // First register index past the end of the register list.
  localparam logic [CfgIdxW-1:0] UnusedRegIdx = 4'd8;

  typedef struct packed {
    logic [PeriodW-1:0] sample;
    logic               edge_bit;
  } check_t;

  typedef struct packed {
    logic [PeriodW-1:0] period;
    logic               range_alarm;
    logic               lost_alarm;
  } line_status_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } reg_write_t;

  logic clk;
  logic rst_n;

  alpq_chk_if chk_bus ();
  alpq_res_if res_bus ();
  alpq_cfg_if cfg_bus ();

  ac_line_period_qualifier_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .chk_i  (chk_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  // Checks still to be offered, line status still to come back, and
  // register writes still to be made.
  check_t       checks_pending[$];
  line_status_t status_due[$];
  reg_write_t   reg_writes_pending[$];

  // The bench's own copy of the register file and of the qualifier state.
  cfg_t               shadow_cfg;
  logic [PeriodW-1:0] held_period;
  logic [CountW-1:0]  run_count;
  logic [CountW-1:0]  sample_count;
  logic [CountW-1:0]  silent_count;
  logic               range_flag;
  logic               lost_flag;

  int unsigned errors;
  int unsigned checks_taken;
  int unsigned results_seen;
  int unsigned periods_taken;
  int unsigned range_raised;
  int unsigned lost_raised;
  int unsigned settings_used;
  int unsigned cycles;
  int unsigned src_gap;
  int unsigned sink_gap;
  int unsigned idle_pct;
  int          line_base;

  // Free-running clock, 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Works out the line status that one check leaves behind, and moves the
  // bench's copy of the state on by that check. The difference between the
  // sample and the held period is formed one bit wider than a period, so
  // that a large jump is never mistaken for a small one.
  function automatic void qualify_check(check_t item);
    logic [PeriodW:0] diff_abs;
    line_status_t     status;
    if (item.edge_bit) begin
      silent_count = '0;
    end
    if (item.sample != '0) begin
      if (item.sample > held_period) begin
        diff_abs = {1'b0, item.sample} - {1'b0, held_period};
      end else begin
        diff_abs = {1'b0, held_period} - {1'b0, item.sample};
      end
      if (diff_abs > {1'b0, shadow_cfg.tolerance}) begin
        if (item.sample > held_period) begin
          // A longer period counts the run up from its neutral value; the
          // eight-bit counter is allowed to wrap.
          if (run_count < shadow_cfg.run_start) begin
            run_count = shadow_cfg.run_start;
          end else begin
            run_count = run_count + 1'b1;
          end
          if (run_count > shadow_cfg.rise_accept) begin
            run_count   = shadow_cfg.run_start;
            held_period = item.sample;
            periods_taken++;
          end
        end else begin
          // A shorter period counts the run down, again with wrap.
          if (run_count > shadow_cfg.run_start) begin
            run_count = shadow_cfg.run_start;
          end else begin
            run_count = run_count - 1'b1;
          end
          if (run_count < shadow_cfg.fall_accept) begin
            run_count   = shadow_cfg.run_start;
            held_period = item.sample;
            periods_taken++;
          end
        end
      end else begin
        run_count = shadow_cfg.run_start;
      end
      if (sample_count != '1) begin
        sample_count = sample_count + 1'b1;
      end
    end
    if (silent_count != '1) begin
      silent_count = silent_count + 1'b1;
    end
    // The range alarm is only judged once start-up is over; until then it
    // keeps whatever value it had.
    if (sample_count >= shadow_cfg.startup_samples) begin
      sample_count = shadow_cfg.startup_samples;
      range_flag   = (held_period > shadow_cfg.upper_limit) ||
                     (held_period < shadow_cfg.lower_limit);
    end
    if (silent_count >= shadow_cfg.missing_limit) begin
      silent_count = shadow_cfg.missing_limit;
      lost_flag    = 1'b1;
    end else begin
      lost_flag = 1'b0;
    end
    status.period      = held_period;
    status.range_alarm = range_flag;
    status.lost_alarm  = lost_flag;
    if (range_flag) begin
      range_raised++;
    end
    if (lost_flag) begin
      lost_raised++;
    end
    status_due.push_back(status);
  endfunction

  // Check driver. The prediction is made at the edge where the item is
  // taken, which keeps it in step with the order the block sees. The valid
  // line gets a single assignment per edge.
  always @(posedge clk) begin
    check_t next_check;
    if (!rst_n) begin
      chk_bus.valid <= 1'b0;
    end else begin
      if (chk_bus.valid && chk_bus.ready) begin
        checks_taken++;
        qualify_check('{sample: chk_bus.period_sample, edge_bit: chk_bus.edge_seen});
      end
      if (!chk_bus.valid || chk_bus.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          chk_bus.valid <= 1'b0;
        end else if (checks_pending.size() != 0) begin
          next_check = checks_pending.pop_front();
          chk_bus.valid         <= 1'b1;
          chk_bus.period_sample <= next_check.sample;
          chk_bus.edge_seen     <= next_check.edge_bit;
          if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            src_gap = $urandom_range(1, 5);
          end
        end else begin
          chk_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Register write driver. The bench's copy of a register changes at the
  // same edge as the block's. Bits above an eight-bit register are dropped,
  // and an index past the list changes nothing.
  always @(posedge clk) begin
    reg_write_t next_write;
    if (!rst_n) begin
      cfg_bus.valid <= 1'b0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_UPPER_LIMIT: shadow_cfg.upper_limit     = cfg_bus.wdata;
          REG_LOWER_LIMIT: shadow_cfg.lower_limit     = cfg_bus.wdata;
          REG_TOLERANCE:   shadow_cfg.tolerance       = cfg_bus.wdata;
          REG_RUN_START:   shadow_cfg.run_start       = cfg_bus.wdata[CountW-1:0];
          REG_RISE_ACCEPT: shadow_cfg.rise_accept     = cfg_bus.wdata[CountW-1:0];
          REG_FALL_ACCEPT: shadow_cfg.fall_accept     = cfg_bus.wdata[CountW-1:0];
          REG_STARTUP:     shadow_cfg.startup_samples = cfg_bus.wdata[CountW-1:0];
          REG_MISSING:     shadow_cfg.missing_limit   = cfg_bus.wdata[CountW-1:0];
          default: ;
        endcase
      end
      if (!cfg_bus.valid || cfg_bus.ready) begin
        if (reg_writes_pending.size() != 0) begin
          next_write = reg_writes_pending.pop_front();
          cfg_bus.valid <= 1'b1;
          cfg_bus.index <= next_write.index;
          cfg_bus.wdata <= next_write.data;
        end else begin
          cfg_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every result taken is held against the oldest line
  // status still due; ready is dropped in random bursts.
  always @(posedge clk) begin
    line_status_t want;
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        results_seen++;
        if (status_due.size() == 0) begin
          errors++;
          $display("%0t: result with no check outstanding: period %0d range %0b lost %0b",
                   $time, res_bus.accepted_period, res_bus.range_alarm,
                   res_bus.signal_lost_alarm);
        end else begin
          want = status_due.pop_front();
          if (res_bus.accepted_period !== want.period) begin
            errors++;
            $display("%0t: accepted_period expected %0d actual %0d",
                     $time, want.period, res_bus.accepted_period);
          end
          if (res_bus.range_alarm !== want.range_alarm) begin
            errors++;
            $display("%0t: range_alarm expected %0b actual %0b",
                     $time, want.range_alarm, res_bus.range_alarm);
          end
          if (res_bus.signal_lost_alarm !== want.lost_alarm) begin
            errors++;
            $display("%0t: signal_lost_alarm expected %0b actual %0b",
                     $time, want.lost_alarm, res_bus.signal_lost_alarm);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          sink_gap = $urandom_range(1, 5);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: no progress after %0d cycles", $time, cycles);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void queue_check(logic [PeriodW-1:0] sample, logic edge_bit);
    checks_pending.push_back('{sample: sample, edge_bit: edge_bit});
  endfunction

  function automatic void queue_reg(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] data);
    reg_writes_pending.push_back('{index: index, data: data});
  endfunction

  // Waits, on falling edges so as to stay clear of the drivers, until every
  // item has been offered and taken and every result has come back, then
  // a little longer than the pipeline is deep.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (checks_pending.size() != 0 || chk_bus.valid || status_due.size() != 0 ||
               reg_writes_pending.size() != 0 || cfg_bus.valid);
    repeat (4) @(negedge clk);
  endtask

  // A plausible random setting: limits around the usual mains band, a run
  // counter with a short rise window and a fall threshold that is usually
  // close to the neutral value. The top byte of every eight-bit register is
  // filled with noise, and a write to an index past the list is added.
  task automatic apply_random_setting();
    int rs;
    int rise;
    int fall;
    rs   = int'($urandom_range(0, 40));
    rise = rs + int'($urandom_range(0, 8));
    if ($urandom_range(0, 3) == 0) begin
      fall = int'($urandom_range(0, 255));
    end else begin
      fall = rs - int'($urandom_range(0, 6));
    end
    if (fall < 0) begin
      fall = 0;
    end
    queue_reg(REG_UPPER_LIMIT, 16'(18000 + $urandom_range(0, 6000)));
    queue_reg(REG_LOWER_LIMIT, 16'(14000 + $urandom_range(0, 5000)));
    if ($urandom_range(0, 4) == 0) begin
      queue_reg(REG_TOLERANCE, 16'($urandom_range(0, 65535)));
    end else begin
      queue_reg(REG_TOLERANCE, 16'($urandom_range(0, 300)));
    end
    queue_reg(REG_RUN_START,   {8'($urandom), 8'(rs)});
    queue_reg(REG_RISE_ACCEPT, {8'($urandom), 8'(rise)});
    queue_reg(REG_FALL_ACCEPT, {8'($urandom), 8'(fall)});
    queue_reg(REG_STARTUP,     {8'($urandom), 8'($urandom_range(0, 40))});
    queue_reg(REG_MISSING,     {8'($urandom), 8'($urandom_range(1, 10))});
    queue_reg(4'(UnusedRegIdx + $urandom_range(0, 7)), 16'($urandom));
    settings_used++;
    wait_idle();
  endtask

  // Random checks in bursts. Most bursts look like a real line: samples
  // jittering around a base period with an edge nearly every time, and now
  // and then a step to a new base held long enough to be taken. The rest
  // are dropouts, edges without a sample, and fully random noise.
  task automatic add_random(int unsigned n);
    int unsigned added;
    int unsigned len;
    int unsigned kind;
    int          s;
    check_t      item;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 8);
      if (kind == 5 || kind == 6) begin
        s = line_base + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(40, 4000));
        line_base = (s < 1000) ? 1000 : (s > 64000) ? 64000 : s;
        len = $urandom_range(1, 12);
      end else if (kind == 7) begin
        len = $urandom_range(1, 10);
      end else if (kind >= 8) begin
        len = $urandom_range(1, 3);
      end
      for (int unsigned i = 0; i < len; i++) begin
        case (kind)
          7: item = '{sample: '0, edge_bit: 1'b0};
          8: item = '{sample: 16'($urandom), edge_bit: 1'($urandom)};
          9: item = '{sample: '0, edge_bit: 1'b1};
          default: begin
            s = line_base + int'($urandom_range(0, 60)) - 30;
            if (s < 1) begin
              s = 1;
            end
            if (s > 65535) begin
              s = 65535;
            end
            item = '{sample: 16'(s), edge_bit: ($urandom_range(0, 9) != 0)};
          end
        endcase
        checks_pending.push_back(item);
      end
      added += len;
    end
    wait_idle();
  endtask

  initial begin
    // Every input of the block is known from time zero.
    rst_n                 = 1'b0;
    chk_bus.valid         = 1'b0;
    chk_bus.period_sample = '0;
    chk_bus.edge_seen     = 1'b0;
    res_bus.ready         = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = '0;
    cfg_bus.wdata         = '0;

    shadow_cfg = '{upper_limit: UpperLimitRst, lower_limit: LowerLimitRst,
                   tolerance: ToleranceRst, run_start: RunStartRst,
                   rise_accept: RiseAcceptRst, fall_accept: FallAcceptRst,
                   startup_samples: StartupRst, missing_limit: MissingRst};
    held_period  = HeldPeriodRst;
    run_count    = RunStartRst;
    sample_count = '0;
    silent_count = '0;
    range_flag   = 1'b0;
    lost_flag    = 1'b0;

    errors        = 0;
    checks_taken  = 0;
    results_seen  = 0;
    periods_taken = 0;
    range_raised  = 0;
    lost_raised   = 0;
    settings_used = 1;
    cycles        = 0;
    src_gap       = 0;
    sink_gap      = 0;
    idle_pct      = 20;
    line_base     = 20000;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed checks under the reset settings. Five checks with neither
    // sample nor edge raise the signal-lost alarm and an edge clears it. A
    // shorter period is taken at once, a sample within tolerance is not, a
    // longer period needs six outliers in a row, and the extremes of the
    // sample field are both taken as periods.
    for (int i = 0; i < 6; i++) begin
      queue_check(16'd0, 1'b0);
    end
    queue_check(16'd0, 1'b1);
    queue_check(16'd19000, 1'b1);
    queue_check(16'd19020, 1'b1);
    for (int i = 0; i < 6; i++) begin
      queue_check(16'hFFFF, 1'b1);
    end
    queue_check(16'd1, 1'b1);
    queue_check(16'd1, 1'b0);
    queue_check(16'h8000, 1'b1);
    queue_check(16'd0, 1'b1);
    wait_idle();

    // Lowest extremes: zero tolerance, a run counter that wraps on the way
    // down so a shorter period is never taken, the range judged from the
    // first check, and a signal-lost alarm that is always set.
    queue_reg(REG_UPPER_LIMIT, 16'hFFFF);
    queue_reg(REG_LOWER_LIMIT, 16'h0000);
    queue_reg(REG_TOLERANCE,   16'h0000);
    queue_reg(REG_RUN_START,   16'h0000);
    queue_reg(REG_RISE_ACCEPT, 16'h0000);
    queue_reg(REG_FALL_ACCEPT, 16'h0000);
    queue_reg(REG_STARTUP,     16'h0000);
    queue_reg(REG_MISSING,     16'h0000);
    settings_used++;
    wait_idle();
    add_random(150);

    // Highest extremes: limits crossed over so the range alarm must come
    // once start-up ends, and all thresholds at full scale, so no sample is
    // ever outside the tolerance. The write past the list must change nothing.
    idle_pct = 35;
    queue_reg(REG_UPPER_LIMIT, 16'h0000);
    queue_reg(REG_LOWER_LIMIT, 16'hFFFF);
    queue_reg(REG_TOLERANCE,   16'hFFFF);
    queue_reg(REG_RUN_START,   16'h00FF);
    queue_reg(REG_RISE_ACCEPT, 16'h00FF);
    queue_reg(REG_FALL_ACCEPT, 16'h00FF);
    queue_reg(REG_STARTUP,     16'h00FF);
    queue_reg(REG_MISSING,     16'h00FF);
    queue_reg(UnusedRegIdx,    16'h0000);
    settings_used++;
    wait_idle();
    add_random(400);

    // Random settings with different amounts of idling.
    for (int p = 0; p < 5; p++) begin
      idle_pct  = (p == 2) ? 0 : 10 + 8 * p;
      line_base = $urandom_range(0, 1) ? 20000 : 16667;
      apply_random_setting();
      add_random(200);
    end

    // Back to the reset settings for a last stretch with no idling at all.
    idle_pct = 0;
    queue_reg(REG_UPPER_LIMIT, UpperLimitRst);
    queue_reg(REG_LOWER_LIMIT, LowerLimitRst);
    queue_reg(REG_TOLERANCE,   ToleranceRst);
    queue_reg(REG_RUN_START,   {8'h00, RunStartRst});
    queue_reg(REG_RISE_ACCEPT, {8'h00, RiseAcceptRst});
    queue_reg(REG_FALL_ACCEPT, {8'h00, FallAcceptRst});
    queue_reg(REG_STARTUP,     {8'h00, StartupRst});
    queue_reg(REG_MISSING,     {8'h00, MissingRst});
    settings_used++;
    wait_idle();
    line_base = 20000;
    add_random(100);

    repeat (8) @(negedge clk);
    $display("Ran %0d checks and %0d results over %0d register settings; %0d new periods taken.",
             checks_taken, results_seen, settings_used, periods_taken);
    $display("Range alarm expected on %0d results, signal-lost alarm on %0d.",
             range_raised, lost_raised);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
